// ----- src/sdcs_pkg.sv -----
package sdcs_pkg;

	localparam int unsigned FreqWidth      = 40;
	localparam int unsigned ClockWidth     = 32;
	localparam int unsigned NWidth         = 42;
	localparam int unsigned D2Width        = 41;
	localparam int unsigned DivSteps       = 32;
	localparam int unsigned MinFreqMillihz = 10;

	localparam logic [ClockWidth-1:0] ClockHzReset    = 32'd50000000;
	localparam logic [FreqWidth-1:0]  MaxFreqReset    = 40'd10000000;
	localparam logic [31:0]           DividerAllOnes  = 32'hFFFF_FFFF;

	localparam logic RegClockHz  = 1'b0;
	localparam logic RegMaxFreq  = 1'b1;

	typedef struct packed {
		logic               rej;
		logic               sat;
		logic [D2Width-1:0] d2;
		logic [D2Width-1:0] rem;
		logic [DivSteps-1:0] nq;
	} div_t;

endpackage

// ----- src/sdcs_div_step.sv -----
module sdcs_div_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  sdcs_pkg::div_t in_st,
	output logic           out_vld,
	output sdcs_pkg::div_t out_st
);
	import sdcs_pkg::*;

	logic               valid_s1;
	div_t               st_s1;
	logic [D2Width:0]   trial;
	logic               ge;
	div_t               nxt;

	always_comb begin
		trial = {in_st.rem, in_st.nq[DivSteps-1]};
		ge    = trial >= {1'b0, in_st.d2};
		nxt   = in_st;
		nxt.rem = ge ? D2Width'(trial - {1'b0, in_st.d2}) : trial[D2Width-1:0];
		nxt.nq  = {in_st.nq[DivSteps-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= nxt;
		end
	end

	assign out_vld = valid_s1;
	assign out_st  = st_s1;

endmodule

// ----- src/sdcs_pick.sv -----
module sdcs_pick (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  sdcs_pkg::div_t in_st,
	output logic           out_vld,
	output logic [31:0]    divider,
	output logic           rejected
);
	import sdcs_pkg::*;

	logic        valid_s1, valid_s2, valid_s3;
	logic        ovr_s1, ovr_s2;
	logic [31:0] ovr_val_s1, ovr_val_s2;
	logic        rej_s1, rej_s2;
	logic [31:0] q_s1, q_s2;
	logic        hi_s1, hi_s2;
	logic [64:0] pl0_s1;
	logic [41:0] pl1_s1;
	logic [63:0] pr0_s1;
	logic [40:0] pr1_s1;
	logic [73:0] l_s2;
	logic [72:0] r_s2;
	logic [31:0] div_s3;
	logic        rej_s3;

	logic [32:0] m;
	logic        ovr;
	logic [31:0] ovr_val;
	logic [31:0] pick;

	always_comb begin
		m = {in_st.nq, 1'b1};
		ovr = 1'b1;
		ovr_val = DividerAllOnes;
		if (in_st.rej || in_st.sat || in_st.nq == DividerAllOnes) begin
			ovr_val = DividerAllOnes;
		end else if (in_st.nq == '0) begin
			ovr_val = 32'd1;
		end else begin
			ovr = 1'b0;
		end
	end

	always_comb begin
		if (hi_s2) begin
			pick = (74'(r_s2) > l_s2) ? q_s2 : q_s2 + 32'd1;
		end else begin
			pick = (74'(r_s2) < l_s2) ? q_s2 + 32'd1 : q_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_vld;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovr_s1     <= ovr;
			ovr_val_s1 <= ovr_val;
			rej_s1     <= in_st.rej;
			q_s1       <= in_st.nq;
			hi_s1      <= {in_st.rem, 1'b0} >= {1'b0, in_st.d2};
			pl0_s1     <= 65'(in_st.rem[31:0]) * 65'(m);
			pl1_s1     <= 42'(in_st.rem[40:32]) * 42'(m);
			pr0_s1     <= 64'(in_st.d2[31:0]) * 64'(in_st.nq);
			pr1_s1     <= 41'(in_st.d2[40:32]) * 41'(in_st.nq);

			ovr_s2     <= ovr_s1;
			ovr_val_s2 <= ovr_val_s1;
			rej_s2     <= rej_s1;
			q_s2       <= q_s1;
			hi_s2      <= hi_s1;
			l_s2       <= 74'(pl0_s1) + {pl1_s1, 32'b0};
			r_s2       <= 73'(pr0_s1) + {pr1_s1, 32'b0};

			rej_s3     <= rej_s2;
			div_s3     <= ovr_s2 ? ovr_val_s2 : pick;
		end
	end

	assign out_vld  = valid_s3;
	assign divider  = div_s3;
	assign rejected = rej_s3;

endmodule

// ----- src/sample_clock_divider_select_core.sv -----
// Pipeline from input transaction to result: entry, divider setup,
// 32 restoring-division stages, two multiply/sum stages, select.
// Throughput: one transaction per cycle; the whole pipeline holds on output stall.
// Reset: arst_n clears all valid bits and loads clock_hz = 50 MHz,
// max_freq_millihz = 10000000.
module sample_clock_divider_select_core #(
	parameter int unsigned MIN_FREQ_MILLIHZ = sdcs_pkg::MinFreqMillihz
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [39:0] target_freq_millihz,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] divider,
	output logic        rejected,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [39:0] cfg_wdata
);
	import sdcs_pkg::*;

	logic [ClockWidth-1:0] clock_hz_q;
	logic [FreqWidth-1:0]  max_freq_q;
	logic                  adv;

	logic                  valid_s1, valid_s2;
	logic [NWidth-1:0]     n_s1;
	logic [D2Width-1:0]    d2_s1;
	logic                  rej_s1;
	div_t                  st_s2;

	div_t                  chain [0:DivSteps];
	logic                  vchain [0:DivSteps];

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= ClockHzReset;
			max_freq_q <= MaxFreqReset;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				RegClockHz: clock_hz_q <= cfg_wdata[ClockWidth-1:0];
				RegMaxFreq: max_freq_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s1   <= NWidth'(clock_hz_q) * NWidth'(1000);
			d2_s1  <= {target_freq_millihz, 1'b0};
			rej_s1 <= (target_freq_millihz > max_freq_q) ||
			          (target_freq_millihz <= FreqWidth'(MIN_FREQ_MILLIHZ));

			st_s2.rej <= rej_s1;
			st_s2.sat <= {31'b0, n_s1} >= {d2_s1, 32'b0};
			st_s2.d2  <= d2_s1;
			st_s2.rem <= D2Width'(n_s1[NWidth-1:DivSteps]);
			st_s2.nq  <= n_s1[DivSteps-1:0];
		end
	end

	assign chain[0]  = st_s2;
	assign vchain[0] = valid_s2;

	for (genvar i = 0; i < DivSteps; i++) begin : g_div
		sdcs_div_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.in_vld (vchain[i]),
			.in_st  (chain[i]),
			.out_vld(vchain[i+1]),
			.out_st (chain[i+1])
		);
	end

	sdcs_pick u_pick (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (vchain[DivSteps]),
		.in_st   (chain[DivSteps]),
		.out_vld (out_valid),
		.divider (divider),
		.rejected(rejected)
	);

endmodule

// ----- test/sdcs_checker.sv -----
`timescale 1ns / 1ps

module sdcs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [39:0] target_freq_millihz,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] divider,
	input  logic        rejected,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [39:0] cfg_wdata,
	output int          fail_count,
	output int          pending
);
	import sdcs_pkg::*;

	typedef struct packed {
		logic [31:0] div;
		logic        rej;
	} pick_t;

	logic [31:0] clock_hz_q;
	logic [39:0] max_freq_q;
	pick_t       expected_picks[$];

	function automatic logic [127:0] dist_num(logic [63:0] k, logic [63:0] n, logic [63:0] d2);
		logic [127:0] prod;
		prod = 128'(k) * 128'(d2);
		return (128'(n) > prod) ? 128'(n) - prod : prod - 128'(n);
	endfunction

	function automatic pick_t pick_divider(logic [39:0] f);
		pick_t        p;
		logic [63:0]  n, d2, k0, k, best;
		logic [63:0]  cands[3];
		logic [127:0] e, best_e;
		bit           have;
		p.rej = 1'b1;
		p.div = DividerAllOnes;
		if (f > max_freq_q || f <= MinFreqMillihz)
			return p;
		n = 64'(clock_hz_q) * 64'd1000;
		d2 = 64'(f) * 64'd2;
		k0 = (n * 2 + d2) / (d2 * 2);
		if (k0 > 64'hFFFF_FFFF)
			k0 = 64'hFFFF_FFFF;
		cands[0] = k0;
		cands[1] = k0 + 1;
		cands[2] = (k0 >= 1) ? k0 - 1 : 64'd0;
		best = 1;
		best_e = '0;
		have = 0;
		for (int i = 0; i < 3; i++) begin
			k = cands[i];
			if (k == 0 || k > 64'hFFFF_FFFF)
				continue;
			e = dist_num(k, n, d2);
			if (!have || e * 128'(best) < best_e * 128'(k)) begin
				best = k;
				best_e = e;
				have = 1;
			end
		end
		p.rej = 1'b0;
		p.div = best[31:0];
		return p;
	endfunction

	assign pending = expected_picks.size();

	always @(posedge clk or negedge arst_n) begin
		pick_t want;
		if (!arst_n) begin
			clock_hz_q <= ClockHzReset;
			max_freq_q <= MaxFreqReset;
			expected_picks.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == RegClockHz)
					clock_hz_q <= cfg_wdata[31:0];
				else
					max_freq_q <= cfg_wdata;
			end
			if (in_valid && in_ready)
				expected_picks.push_back(pick_divider(target_freq_millihz));
			if (out_valid && out_ready) begin
				if (expected_picks.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected transaction: divider %h rejected %b",
							divider, rejected);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_picks.pop_front();
					if (want.div !== divider || want.rej !== rejected) begin
						if (fail_count < 10)
							$display("mismatch: exp divider %h rejected %b, got %h %b",
								want.div, want.rej, divider, rejected);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import sdcs_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [39:0] target_freq_millihz;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] divider;
	logic        rejected;
	logic        cfg_we;
	logic [0:0]  cfg_idx;
	logic [39:0] cfg_wdata;
	int          fail_count;
	int          pending;

	int          send_idle_pct;
	int          recv_stall_pct;
	bit          hold_req;
	logic [39:0] cur_max;
	logic [39:0] edge_freqs[10];

	sample_clock_divider_select_core uut (.*);

	sdcs_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// receiver side
	initial begin
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 0;
				repeat (300) @(posedge clk);
				hold_req = 0;
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic send_freq(logic [39:0] f);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1;
		target_freq_millihz <= f;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [39:0] val);
		drain();
		repeat (45) @(posedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == RegMaxFreq)
			cur_max = val;
	endtask

	function automatic logic [39:0] rand_freq();
		logic [39:0] r;
		logic [63:0] span;
		r = 40'({$urandom, $urandom});
		case ($urandom_range(0, 9))
			0: return r;
			1: return 40'($urandom_range(0, 20));
			2: return cur_max + 40'($urandom_range(0, 6)) - 40'd3;
			3: return 40'($urandom_range(11, 5000));
			default: begin
				if (cur_max <= 11)
					return r;
				span = 64'(cur_max) - 64'd10;
				return 40'(64'(r) % span + 64'd11);
			end
		endcase
	endfunction

	logic [31:0] clocks[7] = '{32'd50000000, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd0,
		32'd12345678, 32'd50000000};
	logic [39:0] maxes[7] = '{40'd10000000, 40'hFF_FFFF_FFFF, 40'd1000,
		40'hFF_FFFF_FFFF, 40'd0, 40'd0, 40'd10000000};

	initial begin
		in_valid = 0;
		target_freq_millihz = '0;
		cfg_we = 0;
		cfg_idx = RegClockHz;
		cfg_wdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 0;
		cur_max = MaxFreqReset;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (clocks[i]) begin
			if (i == 4) begin
				clocks[i] = $urandom;
				maxes[i] = 40'({$urandom, $urandom});
			end
			if (i > 0) begin
				write_reg(RegClockHz, 40'(clocks[i]));
				write_reg(RegMaxFreq, maxes[i]);
			end
			case (i % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			// edges of the request range
			edge_freqs = '{40'd0, 40'd1, 40'd10, 40'd11, 40'd12, 40'd1000, cur_max,
				cur_max + 40'd1, 40'hFF_FFFF_FFFF, 40'h80_0000_0000};
			foreach (edge_freqs[j])
				send_freq(edge_freqs[j]);
			if (i == 2 || i == 5)
				hold_req = 1;
			repeat (125) send_freq(rand_freq());
			drain();
			repeat (125) send_freq(rand_freq());
		end
		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
